// File: src/pdes_pkg.sv
// Shared types, constants and helper functions of the projectile step core.
package pdes_pkg;

  // Fixed-point constants
  localparam logic [19:0] G_Q16    = 20'd642908;
  localparam logic [31:0] RHO0_Q30 = 32'd1315333734;
  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [19:0] HEIGHT_K = 20'd728980;
  localparam logic [16:0] HALF_SEC = 17'd32768;
  localparam logic [40:0] DV_CAP   = 41'h100_0000_0000;
  localparam logic [51:0] EXP_BIAS = 52'h8_0000_0000_0000;
  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;

  // Configuration register indexes
  localparam logic [2:0] REG_DRAG_EN   = 3'd0;
  localparam logic [2:0] REG_MASS      = 3'd1;
  localparam logic [2:0] REG_DRAG_COEF = 3'd2;
  localparam logic [2:0] REG_RADIUS    = 3'd3;
  localparam logic [2:0] REG_START_X   = 3'd4;
  localparam logic [2:0] REG_START_Y   = 3'd5;
  localparam logic [2:0] REG_LAUNCH_VX = 3'd6;
  localparam logic [2:0] REG_LAUNCH_VY = 3'd7;

  // Multiply operations of one step
  typedef enum logic [4:0] {
    OP_GDT, OP_R2, OP_AREA, OP_NUM, OP_AX2, OP_AY2, OP_HGT, OP_LN2,
    OP_TERM, OP_RECIP, OP_RHO, OP_KR, OP_G, OP_AXDT, OP_AYDT,
    OP_DVX, OP_DVY, OP_MVX, OP_MVY
  } op_t;

  typedef struct packed {
    logic       load;
    logic       issue;
    logic       commit;
    logic       vel;
    logic       pos;
    op_t        op;
    logic [3:0] j;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_busy;
    logic sqrt_busy;
    logic out_busy;
    logic drag_en;
  } sts_t;

  // ceil(2^34 / j): exact floor division by j for 30-bit dividends
  function automatic logic [34:0] recip_q34(input logic [3:0] j);
    logic [34:0] m;
    unique case (j)
      4'd1:    m = 35'd17179869184;
      4'd2:    m = 35'd8589934592;
      4'd3:    m = 35'd5726623062;
      4'd4:    m = 35'd4294967296;
      4'd5:    m = 35'd3435973837;
      4'd6:    m = 35'd2863311531;
      4'd7:    m = 35'd2454267027;
      4'd8:    m = 35'd2147483648;
      4'd9:    m = 35'd1908874354;
      4'd10:   m = 35'd1717986919;
      4'd11:   m = 35'd1561806290;
      4'd12:   m = 35'd1431655766;
      default: m = 35'd0;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] sat_s32(input logic signed [42:0] v);
    logic [31:0] r;
    if (v > 43'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -43'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: src/pdes_mul.sv
// Iterative 64x48 multiplier, 16 bits of the second operand per cycle, with saturating shift.
module pdes_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [47:0] b,
  input  logic [5:0]  sh,
  output logic        done,
  output logic [63:0] res
);

  logic         busy;
  logic         shf;
  logic [1:0]   cnt;
  logic [63:0]  ar;
  logic [47:0]  br;
  logic [5:0]   shr;
  logic [111:0] acc;
  logic [79:0]  part;
  logic [111:0] addend;
  logic [111:0] shifted;

  assign part    = 80'(ar) * 80'(br[15:0]);
  assign shifted = acc >> shr;

  always_comb begin
    unique case (cnt)
      2'd0:    addend = {32'b0, part};
      2'd1:    addend = {16'b0, part, 16'b0};
      2'd2:    addend = {part, 32'b0};
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      shf  <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ar   <= a;
        br   <= b;
        shr  <= sh;
        acc  <= '0;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + addend;
        br  <= br >> 16;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd2) begin
          busy <= 1'b0;
          shf  <= 1'b1;
        end
      end else if (shf) begin
        shf  <= 1'b0;
        done <= 1'b1;
        // saturate when the shifted product does not fit 64 bits
        res  <= (|shifted[111:64]) ? 64'hffff_ffff_ffff_ffff : shifted[63:0];
      end
    end
  end

endmodule

// File: src/pdes_sqrt.sv
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
module pdes_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [4:0]  cnt;
  logic [63:0] trial;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      rem  <= val;
      res  <= '0;
      bitm <= 64'h4000_0000_0000_0000;
      cnt  <= 5'd0;
      busy <= 1'b1;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt + 5'd1;
      if (cnt == 5'd31) busy <= 1'b0;
    end
  end

endmodule

// File: src/pdes_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module pdes_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [63:0] quo
);

  logic [63:0] nr;
  logic [31:0] dr;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic [32:0] tr;
  logic        ge;

  assign tr = {rem, nr[63]};
  assign ge = tr >= {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (start) begin
      nr   <= num;
      dr   <= den;
      rem  <= '0;
      cnt  <= 6'd0;
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= ge ? 32'(tr - {1'b0, dr}) : tr[31:0];
      quo  <= {quo[62:0], ge};
      nr   <= nr << 1;
      cnt  <= cnt + 6'd1;
      if (cnt == 6'd63) busy <= 1'b0;
    end
  end

endmodule

// File: src/pdes_dp.sv
// Datapath: configuration, flight state, step temporaries and the shared arithmetic units.
module pdes_dp (
  input  logic                clk,
  input  logic                rst,
  input  pdes_pkg::cmd_t      cmd,
  output pdes_pkg::sts_t      sts,
  input  logic [15:0]         in_dt,
  input  logic [31:0]         in_wx,
  input  logic [31:0]         in_wy,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_pos_x,
  output logic [31:0]         out_pos_y,
  output logic [31:0]         out_vel_x,
  output logic [31:0]         out_vel_y,
  output logic                out_rec
);

  // configuration and flight state
  logic        drag_en;
  logic [31:0] mass;
  logic [19:0] drag_coef;
  logic [23:0] radius;
  logic [31:0] px, py, vx, vy;
  logic [16:0] timer;

  // step temporaries
  logic [15:0] dt_r;
  logic [31:0] ax, ay;
  logic        sgx, sgy;
  logic [19:0] gdt;
  logic [31:0] r2;
  logic [33:0] area;
  logic [63:0] sqx;
  logic [3:0]  nexp;
  logic [29:0] f30;
  logic [29:0] xq;
  logic [29:0] tq;
  logic [30:0] term;
  logic [31:0] ee;
  logic [22:0] rho;
  logic [63:0] kr;
  logic [63:0] gg;
  logic [47:0] pxd, pyd;
  logic [40:0] dvx, dvy;
  logic [31:0] mvx, mvy;

  // arithmetic unit signals
  logic [63:0] ma;
  logic [47:0] mb;
  logic [5:0]  msh;
  logic        mul_done;
  logic [63:0] mres;
  logic        div_go, sqrt_go;
  logic        div_busy, sqrt_busy;
  logic [63:0] kq;
  logic [31:0] sroot;
  logic [31:0] den;
  logic [63:0] sq_sum;

  logic [32:0] rx, ry;
  logic [31:0] y_abs, vx_abs, vy_abs;
  logic [51:0] wexp;
  logic [40:0] dv_cap;
  logic signed [42:0] dxs, dys, nvx, nvy, mxs, mys, npx, npy;
  logic [31:0] nvx32, nvy32;
  logic [16:0] tsum;
  logic        rec;

  assign rx     = {vx[31], vx} - {in_wx[31], in_wx};
  assign ry     = {vy[31], vy} - {in_wy[31], in_wy};
  assign y_abs  = py[31] ? (~py + 32'd1) : py;
  assign vx_abs = vx[31] ? (~vx + 32'd1) : vx;
  assign vy_abs = vy[31] ? (~vy + 32'd1) : vy;
  assign wexp   = py[31] ? (pdes_pkg::EXP_BIAS + 52'(mres[50:0]))
                         : (pdes_pkg::EXP_BIAS - 52'(mres[50:0]));
  assign dv_cap = (mres > 64'(pdes_pkg::DV_CAP)) ? pdes_pkg::DV_CAP : mres[40:0];
  assign den    = (mass == 32'd0) ? 32'd1 : mass;
  assign sq_sum = {2'b0, sqx[63:2]} + {2'b0, mres[63:2]};
  assign div_go  = cmd.commit && (cmd.op == pdes_pkg::OP_NUM);
  assign sqrt_go = cmd.commit && (cmd.op == pdes_pkg::OP_AY2);

  always_comb begin
    unique case (cmd.op)
      pdes_pkg::OP_GDT:   begin ma = 64'(pdes_pkg::G_Q16); mb = 48'(dt_r);     msh = 6'd16; end
      pdes_pkg::OP_R2:    begin ma = 64'(radius);  mb = 48'(radius);           msh = 6'd16; end
      pdes_pkg::OP_AREA:  begin ma = 64'(r2);      mb = 48'(pdes_pkg::PI_Q30); msh = 6'd30; end
      pdes_pkg::OP_NUM:   begin ma = 64'(area);    mb = 48'(drag_coef);        msh = 6'd0;  end
      pdes_pkg::OP_AX2:   begin ma = 64'(ax);      mb = 48'(ax);               msh = 6'd0;  end
      pdes_pkg::OP_AY2:   begin ma = 64'(ay);      mb = 48'(ay);               msh = 6'd0;  end
      pdes_pkg::OP_HGT:   begin ma = 64'(y_abs);   mb = 48'(pdes_pkg::HEIGHT_K); msh = 6'd0; end
      pdes_pkg::OP_LN2:   begin ma = 64'(f30);     mb = 48'(pdes_pkg::LN2_Q30); msh = 6'd30; end
      pdes_pkg::OP_TERM:  begin ma = 64'(term);    mb = 48'(xq);               msh = 6'd30; end
      pdes_pkg::OP_RECIP: begin
        ma  = 64'(tq);
        mb  = 48'(pdes_pkg::recip_q34(cmd.j));
        msh = 6'd34;
      end
      pdes_pkg::OP_RHO:   begin
        ma  = 64'(ee);
        mb  = 48'(pdes_pkg::RHO0_Q30);
        msh = 6'd52 - {2'b0, nexp};
      end
      pdes_pkg::OP_KR:    begin ma = kq;           mb = 48'(rho);              msh = 6'd16; end
      pdes_pkg::OP_G:     begin ma = kr;           mb = 48'({sroot, 1'b0});    msh = 6'd16; end
      pdes_pkg::OP_AXDT:  begin ma = 64'(ax);      mb = 48'(dt_r);             msh = 6'd0;  end
      pdes_pkg::OP_AYDT:  begin ma = 64'(ay);      mb = 48'(dt_r);             msh = 6'd0;  end
      pdes_pkg::OP_DVX:   begin ma = gg;           mb = pxd;                   msh = 6'd48; end
      pdes_pkg::OP_DVY:   begin ma = gg;           mb = pyd;                   msh = 6'd48; end
      pdes_pkg::OP_MVX:   begin ma = 64'(vx_abs);  mb = 48'(dt_r);             msh = 6'd16; end
      pdes_pkg::OP_MVY:   begin ma = 64'(vy_abs);  mb = 48'(dt_r);             msh = 6'd16; end
      default:            begin ma = '0;           mb = '0;                    msh = 6'd0;  end
    endcase
  end

  pdes_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.issue),
    .a     (ma),
    .b     (mb),
    .sh    (msh),
    .done  (mul_done),
    .res   (mres)
  );

  pdes_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   ({3'b0, mres[53:0], 7'b0}),
    .den   (den),
    .busy  (div_busy),
    .quo   (kq)
  );

  pdes_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_go),
    .val   (sq_sum),
    .busy  (sqrt_busy),
    .root  (sroot)
  );

  // load step inputs and commit multiply results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r <= in_dt;
      ax   <= rx[32] ? 32'(~rx + 33'd1) : rx[31:0];
      ay   <= ry[32] ? 32'(~ry + 33'd1) : ry[31:0];
      sgx  <= rx[32];
      sgy  <= ry[32];
    end
    if (cmd.commit) begin
      unique case (cmd.op)
        pdes_pkg::OP_GDT:   gdt  <= mres[19:0];
        pdes_pkg::OP_R2:    r2   <= mres[31:0];
        pdes_pkg::OP_AREA:  area <= mres[33:0];
        pdes_pkg::OP_NUM:   ;
        pdes_pkg::OP_AX2:   sqx  <= mres;
        pdes_pkg::OP_AY2:   ;
        pdes_pkg::OP_HGT:   begin
          nexp <= wexp[51:48];
          f30  <= wexp[47:18];
        end
        pdes_pkg::OP_LN2:   begin
          xq   <= mres[29:0];
          term <= pdes_pkg::ONE_Q30[30:0];
          ee   <= pdes_pkg::ONE_Q30;
        end
        pdes_pkg::OP_TERM:  tq <= mres[29:0];
        pdes_pkg::OP_RECIP: begin
          term <= {1'b0, mres[29:0]};
          ee   <= ee + 32'(mres[29:0]);
        end
        pdes_pkg::OP_RHO:   rho <= mres[22:0];
        pdes_pkg::OP_KR:    kr  <= mres;
        pdes_pkg::OP_G:     gg  <= mres;
        pdes_pkg::OP_AXDT:  pxd <= mres[47:0];
        pdes_pkg::OP_AYDT:  pyd <= mres[47:0];
        pdes_pkg::OP_DVX:   dvx <= dv_cap;
        pdes_pkg::OP_DVY:   dvy <= dv_cap;
        pdes_pkg::OP_MVX:   mvx <= mres[31:0];
        pdes_pkg::OP_MVY:   mvy <= mres[31:0];
        default: ;
      endcase
    end
  end

  // velocity and position update
  always_comb begin
    dxs = '0;
    dys = '0;
    if (drag_en) begin
      dxs = sgx ? $signed({2'b0, dvx}) : -$signed({2'b0, dvx});
      dys = sgy ? $signed({2'b0, dvy}) : -$signed({2'b0, dvy});
    end
    nvx   = $signed({{11{vx[31]}}, vx}) + dxs;
    nvy   = $signed({{11{vy[31]}}, vy}) - $signed({23'b0, gdt}) + dys;
    nvx32 = pdes_pkg::sat_s32(nvx);
    nvy32 = pdes_pkg::sat_s32(nvy);
    mxs   = vx[31] ? -$signed({11'b0, mvx}) : $signed({11'b0, mvx});
    mys   = vy[31] ? -$signed({11'b0, mvy}) : $signed({11'b0, mvy});
    npx   = $signed({{11{px[31]}}, px}) + mxs;
    npy   = $signed({{11{py[31]}}, py}) + mys;
    tsum  = timer + 17'(dt_r);
    rec   = drag_en || (tsum > pdes_pkg::HALF_SEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_en   <= 1'b1;
      mass      <= 32'd134218;
      drag_coef <= 20'd19661;
      radius    <= 24'd63921;
      px        <= 32'd0;
      py        <= 32'd0;
      vx        <= 32'd46530560;
      vy        <= 32'd0;
      timer     <= 17'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.vel) begin
        vx <= nvx32;
        vy <= nvy32;
      end
      if (cmd.pos) begin
        px        <= pdes_pkg::sat_s32(npx);
        py        <= pdes_pkg::sat_s32(npy);
        out_pos_x <= pdes_pkg::sat_s32(npx);
        out_pos_y <= pdes_pkg::sat_s32(npy);
        out_vel_x <= vx;
        out_vel_y <= vy;
        out_rec   <= rec;
        out_valid <= 1'b1;
        // timer holds while drag is on
        if (!drag_en) timer <= rec ? 17'd0 : tsum;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          pdes_pkg::REG_DRAG_EN:   drag_en   <= cfg_data[0];
          pdes_pkg::REG_MASS:      mass      <= cfg_data;
          pdes_pkg::REG_DRAG_COEF: drag_coef <= cfg_data[19:0];
          pdes_pkg::REG_RADIUS:    radius    <= cfg_data[23:0];
          pdes_pkg::REG_START_X:   px        <= cfg_data;
          pdes_pkg::REG_START_Y:   py        <= cfg_data;
          pdes_pkg::REG_LAUNCH_VX: vx        <= cfg_data;
          pdes_pkg::REG_LAUNCH_VY: vy        <= cfg_data;
        endcase
      end
    end
  end

  assign sts.mul_done  = mul_done;
  assign sts.div_busy  = div_busy;
  assign sts.sqrt_busy = sqrt_busy;
  assign sts.out_busy  = out_valid && !out_ready;
  assign sts.drag_en   = drag_en;

endmodule

// File: src/pdes_ctrl.sv
// Controller: sequences the multiply operations of one step and the state updates.
module pdes_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pdes_pkg::sts_t sts,
  output pdes_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_WAIT  = 6'b000100,
    S_SYNC  = 6'b001000,
    S_VEL   = 6'b010000,
    S_POS   = 6'b100000
  } state_t;

  state_t          state, state_next;
  pdes_pkg::op_t   op, op_next;
  logic [3:0]      jcnt, jcnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    jcnt_next  = jcnt;
    cmd        = '0;
    cmd.op     = op;
    cmd.j      = jcnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = pdes_pkg::OP_GDT;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.mul_done) begin
          cmd.commit = 1'b1;
          state_next = S_ISSUE;
          unique case (op)
            pdes_pkg::OP_GDT: begin
              if (sts.drag_en) op_next = pdes_pkg::OP_R2;
              else state_next = S_VEL;
            end
            pdes_pkg::OP_R2:    op_next = pdes_pkg::OP_AREA;
            pdes_pkg::OP_AREA:  op_next = pdes_pkg::OP_NUM;
            pdes_pkg::OP_NUM:   op_next = pdes_pkg::OP_AX2;
            pdes_pkg::OP_AX2:   op_next = pdes_pkg::OP_AY2;
            pdes_pkg::OP_AY2:   op_next = pdes_pkg::OP_HGT;
            pdes_pkg::OP_HGT:   op_next = pdes_pkg::OP_LN2;
            pdes_pkg::OP_LN2: begin
              op_next   = pdes_pkg::OP_TERM;
              jcnt_next = 4'd1;
            end
            pdes_pkg::OP_TERM:  op_next = pdes_pkg::OP_RECIP;
            pdes_pkg::OP_RECIP: begin
              if (jcnt == 4'd12) begin
                op_next = pdes_pkg::OP_RHO;
              end else begin
                op_next   = pdes_pkg::OP_TERM;
                jcnt_next = jcnt + 4'd1;
              end
            end
            pdes_pkg::OP_RHO: begin
              op_next    = pdes_pkg::OP_KR;
              state_next = S_SYNC;
            end
            pdes_pkg::OP_KR:    op_next = pdes_pkg::OP_G;
            pdes_pkg::OP_G:     op_next = pdes_pkg::OP_AXDT;
            pdes_pkg::OP_AXDT:  op_next = pdes_pkg::OP_AYDT;
            pdes_pkg::OP_AYDT:  op_next = pdes_pkg::OP_DVX;
            pdes_pkg::OP_DVX:   op_next = pdes_pkg::OP_DVY;
            pdes_pkg::OP_DVY:   state_next = S_VEL;
            pdes_pkg::OP_MVX:   op_next = pdes_pkg::OP_MVY;
            pdes_pkg::OP_MVY:   state_next = S_POS;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_SYNC: begin
        // hold until drag factor and speed are ready
        if (!sts.div_busy && !sts.sqrt_busy) state_next = S_ISSUE;
      end
      S_VEL: begin
        cmd.vel    = 1'b1;
        op_next    = pdes_pkg::OP_MVX;
        state_next = S_ISSUE;
      end
      S_POS: begin
        if (!sts.out_busy) begin
          cmd.pos    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= pdes_pkg::OP_GDT;
      jcnt  <= 4'd0;
    end else begin
      state <= state_next;
      op    <= op_next;
      jcnt  <= jcnt_next;
    end
  end

  a_accept_issue: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_ISSUE && op == pdes_pkg::OP_GDT))
    else $error("accepted request did not start the gravity product");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == S_WAIT))
    else $error("multiplier finished outside the wait state");

  a_sync_release: assert property (@(posedge clk) disable iff (rst)
    (state == S_SYNC && !sts.div_busy && !sts.sqrt_busy)
      |=> (state == S_ISSUE && op == pdes_pkg::OP_KR))
    else $error("sync did not release into the drag product");

  a_series_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE && (op == pdes_pkg::OP_RECIP || op == pdes_pkg::OP_TERM))
      |-> (jcnt >= 4'd1 && jcnt <= 4'd12))
    else $error("series index out of range");

endmodule

// File: src/projectile_drag_euler_step_core.sv
// Top level of the projectile Euler step core.
//
// One request on the slave stream is one time step: dt and the wind vector.
// The core advances its stored position and velocity by one semi-implicit
// Euler step (gravity, plus quadratic drag with exponential air density when
// drag is enabled) and returns the new position, velocity and a path-record
// flag on the master stream. Configuration writes go through cfg_we/
// cfg_index/cfg_data while the core is idle (the user's duty; the core does
// not check it); launch registers load the state at once. With drag a step
// takes 41 products on one iterative 64x48 multiplier, with the divider and
// square root alongside; without drag, only the gravity and two position
// products. Requests are taken one at a time, when the controller is idle.
// The result sits in an output register; the next request is accepted while
// it waits, and only the final state update stalls while the receiver holds
// m_tready low. Reset loads the documented register defaults and the launch
// state, and clears the record timer and the output valid flag.
module projectile_drag_euler_step_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // dt[15:0], wind_vx[47:16], wind_vy[79:48]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y, 32 bits each
  output logic         m_tuser,   // record_point
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  pdes_pkg::cmd_t cmd;
  pdes_pkg::sts_t sts;
  logic [31:0]    pos_x, pos_y, vel_x, vel_y;

  pdes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdes_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_dt     (s_tdata[15:0]),
    .in_wx     (s_tdata[47:16]),
    .in_wy     (s_tdata[79:48]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pos_x (pos_x),
    .out_pos_y (pos_y),
    .out_vel_x (vel_x),
    .out_vel_y (vel_y),
    .out_rec   (m_tuser)
  );

  assign m_tdata = {vel_y, vel_x, pos_y, pos_x};

endmodule
